/* src/sha256_hash_macros.svh */
// assertion macros for the sha256 block
`ifndef SHA256_HASH_MACROS_SVH
`define SHA256_HASH_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

/* src/sha_pkg.sv */
// types, constants and round functions shared by the sha256 modules
`timescale 1ns / 1ps
package sha_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic       clear;      // restore initial hash, zero length
        logic       wr_byte;    // write byte into block at fill pointer
        logic [7:0] wr_data;
        logic       count;      // add eight to the bit length
        logic       fill_zero;  // write zero or length byte at pointer
        logic       fill_len;   // this block carries the length field
        logic       load;       // start compression: hash into working set
        logic       round;      // run one round
        logic       fold;       // add working set into hash
        logic       shift_out;  // rotate hash words for output
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] ptr;        // fill pointer
        logic [5:0] rnd;        // round counter
        word_t      head_word;  // hash word 0
    } dp_stat_t;

    function automatic word_t ror(input word_t x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* src/sha256_hash.sv */
// sha256 top level: streaming byte input, digest word output
`timescale 1ns / 1ps
// SHA-256 over a byte stream. Each input transfer carries one byte (tuser[0]
// set) or none, and tlast ends the message; eight digest words follow, word 0
// first, tlast on the eighth. Input takes a byte a cycle while idle; each full
// 64-byte block then stalls input while it is compressed (load, 64 rounds of
// the single round unit, fold). Finalising writes the padding a byte a cycle
// and runs one or two further compressions before the digest appears.
module sha256_hash
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word, word_index, zero fill
    output logic        m_tlast    // last_word
);
    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [2:0] idx;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_has    (s_tuser),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (idx),
        .cmd       (cmd),
        .stat      (stat)
    );

    sha_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign m_tdata = {5'd0, idx, stat.head_word};
    assign m_tlast = (idx == 3'd7);
endmodule

/* src/sha_dp.sv */
// sha256 datapath: block store, schedule, round unit and hash words
`timescale 1ns / 1ps
module sha_dp
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat
);
    logic [5:0]  ptr_reg, ptr_next;
    logic [5:0]  rnd_reg;
    logic [63:0] bits_reg;
    word_t       hash_reg [8];
    word_t       wk_reg [8];
    word_t       w_reg [16];
    word_t       w_cur, w_new, t1, t2, s0, s1;
    logic [7:0]  fill_byte;
    logic [2:0]  len_sel;

    // padding byte: zero, or length byte once the pointer reaches 56 in the length block
    always_comb
    begin
        len_sel = ptr_reg[2:0];
        if (cmd.fill_len && ptr_reg >= 6'd56)
            fill_byte = bits_reg[8'(63 - 8 * len_sel) -: 8];
        else
            fill_byte = 8'h00;
    end

    // schedule word for the current round
    always_comb
    begin
        s0    = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = (rnd_reg < 6'd16) ? w_reg[0] : w_new;
        t1 = wk_reg[7] + (ror(wk_reg[4], 6) ^ ror(wk_reg[4], 11) ^ ror(wk_reg[4], 25))
            + ((wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6])) + ROUND_K[rnd_reg] + w_cur;
        t2 = (ror(wk_reg[0], 2) ^ ror(wk_reg[0], 13) ^ ror(wk_reg[0], 22))
            + ((wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]));
    end

    assign ptr_next = ptr_reg + 6'd1;

    // schedule window loads bytes while the block fills, a byte a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte || cmd.fill_zero)
        begin
            w_reg[ptr_reg[5:2]][8'(31 - 8 * ptr_reg[1:0]) -: 8] <=
                cmd.wr_byte ? cmd.wr_data : fill_byte;
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_cur;
        end
        if (cmd.load)
        begin
            for (int i = 0; i < 8; i++)
                wk_reg[i] <= hash_reg[i];
        end
        else if (cmd.round)
        begin
            wk_reg[7] <= wk_reg[6];
            wk_reg[6] <= wk_reg[5];
            wk_reg[5] <= wk_reg[4];
            wk_reg[4] <= wk_reg[3] + t1;
            wk_reg[3] <= wk_reg[2];
            wk_reg[2] <= wk_reg[1];
            wk_reg[1] <= wk_reg[0];
            wk_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            rnd_reg  <= '0;
            bits_reg <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            if (cmd.wr_byte || cmd.fill_zero)
                ptr_reg <= ptr_next;
            if (cmd.count)
                bits_reg <= bits_reg + 64'd8;
            if (cmd.load)
                rnd_reg <= '0;
            else if (cmd.round)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.clear)
            begin
                ptr_reg  <= '0;
                bits_reg <= '0;
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= INIT_HASH[i];
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + wk_reg[i];
            end
            else if (cmd.shift_out)
            begin
                for (int i = 0; i < 7; i++)
                    hash_reg[i] <= hash_reg[i + 1];
                hash_reg[7] <= hash_reg[0];
            end
        end
    end

    assign stat.ptr       = ptr_reg;
    assign stat.rnd       = rnd_reg;
    assign stat.head_word = hash_reg[0];
endmodule

/* src/sha_ctrl.sv */
// sha256 controller: byte intake, padding, rounds and digest output
`timescale 1ns / 1ps
`include "sha256_hash_macros.svh"
module sha_ctrl
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic [7:0] in_byte,
    input  logic     in_has,
    input  logic     in_last,
    output logic     out_valid,
    input  logic     out_ready,
    output logic [2:0] out_index,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_FOLD  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;     // finishing the message
    logic       pad_reg, pad_next;     // 0x80 already written
    logic [2:0] idx_reg, idx_next;
    logic       last_blk_reg, last_blk_next;
    logic       take;

    assign in_ready  = (state_reg == S_IDLE);
    assign take      = in_valid && in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.wr_data = in_has ? in_byte : PAD_BYTE;
        cmd.fill_len = last_blk_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && (in_has || in_last))
                begin
                    cmd.wr_byte = 1'b1;
                    cmd.count   = in_has;
                    fin_next    = in_last;
                    pad_next    = in_last && !in_has;
                    // a byte or a pad byte in the last slot fills the block
                    if (stat.ptr == 6'd63)
                        state_next = S_LOAD;
                    else if (in_last)
                        state_next = S_PAD;
                    if (!in_has && in_last)
                        cmd.wr_data = PAD_BYTE;
                end
            end
            S_PAD:
            begin
                // write 0x80 first if not done, then zeros and length
                cmd.fill_zero = pad_reg;
                cmd.wr_byte   = !pad_reg;
                cmd.wr_data   = PAD_BYTE;
                pad_next      = 1'b1;
                if (stat.ptr == 6'd63)
                    state_next = S_LOAD;
                else if (stat.ptr == 6'd0 && pad_reg)
                    state_next = S_PAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.rnd == 6'd63)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold = 1'b1;
                if (!fin_reg)
                    state_next = S_IDLE;
                else if (pad_reg && stat.ptr == 6'd0 && last_blk_reg)
                begin
                    state_next = S_OUT;
                    idx_next   = '0;
                end
                else
                    state_next = S_PAD;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.shift_out = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.clear  = 1'b1;
                        fin_next   = 1'b0;
                        pad_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // length block marker: the block where 0x80 lands before byte 56,
    // or the extra block that follows when it lands later
    always_comb
    begin
        last_blk_next = last_blk_reg;
        if ((state_reg == S_IDLE && take && !in_has && in_last && stat.ptr < 6'd56)
            || (state_reg == S_PAD && !pad_reg && stat.ptr < 6'd56)
            || (state_reg == S_FOLD && fin_reg && pad_reg))
            last_blk_next = 1'b1;
        if (state_reg == S_OUT)
            last_blk_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fin_reg      <= 1'b0;
            pad_reg      <= 1'b0;
            idx_reg      <= '0;
            last_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fin_reg      <= fin_next;
            pad_reg      <= pad_next;
            idx_reg      <= idx_next;
            last_blk_reg <= last_blk_next;
        end
    end

    `SHA_ASSERT_IMPL(a_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `SHA_ASSERT_NEXT(a_round_end, clk, rst_n, (state_reg == S_ROUND && stat.rnd == 6'd63), (state_reg == S_FOLD), "rounds did not end in fold")
    `SHA_ASSERT_NEXT(a_out_wrap, clk, rst_n, (out_valid && out_ready && idx_reg == 3'd7), (state_reg == S_IDLE), "digest did not end")
endmodule
